// ----- rtl/lla_pkg.sv -----
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types and constants for the life-like automaton step block.
// ----------------------------------------------------------------------------
package lla_pkg;

  // default grid geometry and cell age width
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int AGE_BITS_DEF   = 4;

  // fixed field widths of the ports
  localparam int AGE_W     = 4;
  localparam int LIVE_W    = 13;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_W    = 7;
  localparam int MASK_W    = 9;

  // request types
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_EDGES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_START   = 3'd5;

  // per-cell visit: slot 0 reads the center, slots 1..8 the neighbors,
  // slot 9 takes the last neighbor and writes the new cell
  localparam int          SLOT_W        = 4;
  localparam logic [3:0]  SLOT_CENTER   = 4'd0;
  localparam logic [3:0]  SLOT_LAST_NBR = 4'd8;
  localparam logic [3:0]  SLOT_WRITE    = 4'd9;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [5:0]       cell_x;
    logic [5:0]       cell_y;
    logic             load_alive;
    logic [AGE_W-1:0] load_age;
  } req_t;

  typedef struct packed {
    logic              read_alive;
    logic [AGE_W-1:0]  read_age;
    logic [LIVE_W-1:0] live_count;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_COPY,
    ST_FLUSH
  } state_t;

  // control from the sequencer to the rule unit
  typedef struct packed {
    logic clear;    // start of a generation
    logic acc_ctr;  // read data is the center cell
    logic acc_nbr;  // read data is a neighbor that counts
    logic finish;   // last neighbor arrives, new cell is due
  } rule_ctl_t;

endpackage

// ----- rtl/lla_ram.sv -----
// ----------------------------------------------------------------------------
// lla_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lla_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lla_nbr_gen.sv -----
// ----------------------------------------------------------------------------
// lla_nbr_gen
// Neighbor address generator: maps a cell and a visit slot to a grid address,
// applying torus wrap or flagging positions beyond a dead border.
// ----------------------------------------------------------------------------
module lla_nbr_gen #(
  parameter int MAX_WIDTH  = lla_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lla_pkg::MAX_HEIGHT_DEF,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT),
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic [XW-1:0]             x,
  input  logic [YW-1:0]             y,
  input  logic [XW-1:0]             x_last,
  input  logic [YW-1:0]             y_last,
  input  logic                      wrap,
  input  logic [lla_pkg::SLOT_W-1:0] slot,
  output logic [AW-1:0]             addr,
  output logic                      valid
);

  logic          dxm, dxp, dym, dyp;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic          vx, vy;

  always_comb begin
    {dxm, dxp, dym, dyp} = 4'b0000;
    unique case (slot)
      4'd1:    {dxm, dym} = 2'b11;
      4'd2:    dym = 1'b1;
      4'd3:    {dxp, dym} = 2'b11;
      4'd4:    dxm = 1'b1;
      4'd5:    dxp = 1'b1;
      4'd6:    {dxm, dyp} = 2'b11;
      4'd7:    dyp = 1'b1;
      4'd8:    {dxp, dyp} = 2'b11;
      default: {dxm, dxp, dym, dyp} = 4'b0000;
    endcase
  end

  always_comb begin
    nx = x;
    vx = 1'b1;
    if (dxm) begin
      if (x == '0) begin
        nx = x_last;
        vx = wrap;
      end else begin
        nx = x - XW'(1);
      end
    end else if (dxp) begin
      if (x == x_last) begin
        nx = '0;
        vx = wrap;
      end else begin
        nx = x + XW'(1);
      end
    end
  end

  always_comb begin
    ny = y;
    vy = 1'b1;
    if (dym) begin
      if (y == '0) begin
        ny = y_last;
        vy = wrap;
      end else begin
        ny = y - YW'(1);
      end
    end else if (dyp) begin
      if (y == y_last) begin
        ny = '0;
        vy = wrap;
      end else begin
        ny = y + YW'(1);
      end
    end
  end

  // row-major with a fixed stride of MAX_WIDTH
  assign addr  = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);
  assign valid = vx & vy;

endmodule

// ----- rtl/lla_rule.sv -----
// ----------------------------------------------------------------------------
// lla_rule
// Rule unit: accumulates the neighbor count and the live count from the
// stream of grid reads and forms the next state of the current cell.
// ----------------------------------------------------------------------------
module lla_rule #(
  parameter int AGE_BITS = lla_pkg::AGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lla_pkg::rule_ctl_t            ctl,
  input  logic [AGE_BITS:0]             rd_cell,
  input  logic [lla_pkg::MASK_W-1:0]    birth_mask,
  input  logic [lla_pkg::MASK_W-1:0]    survive_mask,
  input  logic [AGE_BITS-1:0]           fade,
  output logic [AGE_BITS:0]             nxt_cell,
  output logic [lla_pkg::LIVE_W-1:0]    live_count
);

  logic [3:0]                 cnt_r, cnt_nxt;
  logic [AGE_BITS:0]          cell_r, cell_nxt;
  logic [lla_pkg::LIVE_W-1:0] live_r, live_nxt;
  logic [3:0]                 n_final;
  logic                       alive;

  always_comb begin
    cnt_nxt  = cnt_r;
    cell_nxt = cell_r;
    live_nxt = live_r;
    if (ctl.clear) begin
      cnt_nxt  = '0;
      live_nxt = '0;
    end else begin
      if (ctl.acc_ctr) begin
        cell_nxt = rd_cell;
        live_nxt = live_r + lla_pkg::LIVE_W'(rd_cell[AGE_BITS]);
      end
      if (ctl.finish) begin
        cnt_nxt = '0;
      end else if (ctl.acc_nbr && rd_cell[AGE_BITS]) begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      live_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      live_r <= live_nxt;
    end
    cell_r <= cell_nxt;
  end

  // the eighth neighbor lands in the same cycle as the write
  assign n_final = cnt_r + 4'(ctl.acc_nbr & rd_cell[AGE_BITS]);
  assign alive   = cell_r[AGE_BITS];

  always_comb begin
    nxt_cell = cell_r;
    if (cell_r[AGE_BITS-1:0] != '0) begin
      nxt_cell = cell_r - (AGE_BITS + 1)'(1);
    end
    if (alive && !survive_mask[n_final]) begin
      nxt_cell = {1'b0, fade};
    end
    if (!alive && birth_mask[n_final]) begin
      nxt_cell = {1'b1, fade};
    end
  end

  assign live_count = live_r;

endmodule

// ----- rtl/life_like_automaton_step.sv -----
// ----------------------------------------------------------------------------
// life_like_automaton_step
// Life-like cellular automaton with a B/S rule and fading cell ages.
// ----------------------------------------------------------------------------
// A load returns its (all-zero) result in the cycle after the transfer and the
// block is ready again at once; a read is busy in its read state and returns
// its result through the result register. A step visits every active cell
// (nine reads of the single read port of the current-grid memory, center plus
// eight neighbors, then the write of the new cell), then copies the new grid
// back at one cell per cycle and passes a flush state before the live count is
// registered. Results are single-cycle strobes that the receiver must take as
// they come.
// ----------------------------------------------------------------------------
module life_like_automaton_step #(
  parameter int MAX_WIDTH  = lla_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lla_pkg::MAX_HEIGHT_DEF,
  parameter int AGE_BITS   = lla_pkg::AGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lla_pkg::req_t                 in_req,
  output logic                          out_strobe,
  output lla_pkg::res_t                 out_res,
  input  logic                          cfg_we,
  input  logic [lla_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lla_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW    = AGE_BITS + 1;
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int SW    = (MW + 1 > lla_pkg::SIZE_W) ? MW + 1 : lla_pkg::SIZE_W;

  // configuration
  logic [lla_pkg::SIZE_W-1:0] gw_r, gh_r;
  logic                       wrap_r;
  logic [lla_pkg::MASK_W-1:0] birth_r, surv_r;
  logic [lla_pkg::AGE_W-1:0]  fade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r    <= 7'd64;
      gh_r    <= 7'd64;
      wrap_r  <= 1'b0;
      birth_r <= 9'd8;
      surv_r  <= 9'd12;
      fade_r  <= 4'd15;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lla_pkg::CFG_GRID_WIDTH:   gw_r    <= cfg_wdata[lla_pkg::SIZE_W-1:0];
        lla_pkg::CFG_GRID_HEIGHT:  gh_r    <= cfg_wdata[lla_pkg::SIZE_W-1:0];
        lla_pkg::CFG_WRAP_EDGES:   wrap_r  <= cfg_wdata[0];
        lla_pkg::CFG_BIRTH_MASK:   birth_r <= cfg_wdata;
        lla_pkg::CFG_SURVIVE_MASK: surv_r  <= cfg_wdata;
        lla_pkg::CFG_FADE_START:   fade_r  <= cfg_wdata[lla_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // active size, clamped to 1..MAX
  logic [SW-1:0] aw, ah, aw_m1, ah_m1;
  logic [XW-1:0] x_last;
  logic [YW-1:0] y_last;

  always_comb begin
    aw = SW'(gw_r);
    if (gw_r == '0) begin
      aw = SW'(1);
    end else if (SW'(gw_r) > SW'(MAX_WIDTH)) begin
      aw = SW'(MAX_WIDTH);
    end
    ah = SW'(gh_r);
    if (gh_r == '0) begin
      ah = SW'(1);
    end else if (SW'(gh_r) > SW'(MAX_HEIGHT)) begin
      ah = SW'(MAX_HEIGHT);
    end
  end

  assign aw_m1  = aw - SW'(1);
  assign ah_m1  = ah - SW'(1);
  assign x_last = aw_m1[XW-1:0];
  assign y_last = ah_m1[YW-1:0];

  // request decode
  logic          accept, in_area;
  logic [SW-1:0] req_x_ext, req_y_ext;
  logic [AGE_BITS+lla_pkg::AGE_W-1:0] ld_age_ext;

  assign accept     = start & ~busy;
  assign req_x_ext  = SW'(in_req.cell_x);
  assign req_y_ext  = SW'(in_req.cell_y);
  assign in_area    = (req_x_ext < aw) && (req_y_ext < ah);
  assign ld_age_ext = (AGE_BITS + lla_pkg::AGE_W)'(in_req.load_age);

  // sequencer state
  lla_pkg::state_t state_r, state_nxt;
  logic [XW-1:0]   x_r;
  logic [YW-1:0]   y_r;
  logic [lla_pkg::SLOT_W-1:0] slot_r;
  logic            in_area_r;
  logic            acc_ctr_r, acc_nbr_r;
  logic            cp_v_r;
  logic [AW-1:0]   cp_addr_r;
  logic            last_cell;

  assign last_cell = (x_r == x_last) && (y_r == y_last);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lla_pkg::ST_IDLE: begin
        if (accept && in_req.req_type == lla_pkg::REQ_READ) begin
          state_nxt = lla_pkg::ST_READ;
        end else if (accept && in_req.req_type == lla_pkg::REQ_STEP) begin
          state_nxt = lla_pkg::ST_STEP;
        end
      end
      lla_pkg::ST_READ:  state_nxt = lla_pkg::ST_IDLE;
      lla_pkg::ST_STEP: begin
        if (slot_r == lla_pkg::SLOT_WRITE && last_cell) begin
          state_nxt = lla_pkg::ST_COPY;
        end
      end
      lla_pkg::ST_COPY: begin
        if (last_cell) begin
          state_nxt = lla_pkg::ST_FLUSH;
        end
      end
      lla_pkg::ST_FLUSH: state_nxt = lla_pkg::ST_IDLE;
      default:           state_nxt = lla_pkg::ST_IDLE;
    endcase
  end

  // address unit operands and control outputs
  logic [XW-1:0]              ag_x;
  logic [YW-1:0]              ag_y;
  logic [lla_pkg::SLOT_W-1:0] ag_slot;
  logic [AW-1:0]              ag_addr;
  logic                       ag_valid;
  logic                       step_read, xy_adv, xy_clr;
  logic                       load_we, next_we;
  lla_pkg::rule_ctl_t         rctl;

  always_comb begin
    busy      = 1'b1;
    ag_x      = x_r;
    ag_y      = y_r;
    ag_slot   = lla_pkg::SLOT_CENTER;
    step_read = 1'b0;
    xy_adv    = 1'b0;
    xy_clr    = 1'b0;
    load_we   = 1'b0;
    next_we   = 1'b0;
    rctl      = '0;
    rctl.acc_ctr = acc_ctr_r;
    rctl.acc_nbr = acc_nbr_r;
    unique case (state_r)
      lla_pkg::ST_IDLE: begin
        busy = 1'b0;
        ag_x = req_x_ext[XW-1:0];
        ag_y = req_y_ext[YW-1:0];
        load_we    = accept && in_req.req_type == lla_pkg::REQ_LOAD && in_area;
        xy_clr     = accept && in_req.req_type == lla_pkg::REQ_STEP;
        rctl.clear = xy_clr;
      end
      lla_pkg::ST_STEP: begin
        if (slot_r == lla_pkg::SLOT_WRITE) begin
          next_we     = 1'b1;
          xy_adv      = 1'b1;
          rctl.finish = 1'b1;
        end else begin
          ag_slot   = slot_r;
          step_read = 1'b1;
        end
      end
      lla_pkg::ST_COPY: xy_adv = 1'b1;
      default: ;
    endcase
  end

  lla_nbr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_nbr_gen (
    .x      (ag_x),
    .y      (ag_y),
    .x_last (x_last),
    .y_last (y_last),
    .wrap   (wrap_r),
    .slot   (ag_slot),
    .addr   (ag_addr),
    .valid  (ag_valid)
  );

  // grid memories
  logic          now_we;
  logic [AW-1:0] now_waddr;
  logic [CW-1:0] now_wdata, now_rdata, next_rdata, nxt_cell;

  always_comb begin
    now_we    = load_we | cp_v_r;
    now_waddr = cp_v_r ? cp_addr_r : ag_addr;
    now_wdata = cp_v_r ? next_rdata : {in_req.load_alive, ld_age_ext[AGE_BITS-1:0]};
  end

  lla_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_grid_now (
    .clk   (clk),
    .we    (now_we),
    .waddr (now_waddr),
    .wdata (now_wdata),
    .raddr (ag_addr),
    .rdata (now_rdata)
  );

  lla_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_grid_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (ag_addr),
    .wdata (nxt_cell),
    .raddr (ag_addr),
    .rdata (next_rdata)
  );

  // rule unit
  logic [AGE_BITS+lla_pkg::AGE_W-1:0] fade_ext;
  logic [lla_pkg::LIVE_W-1:0]         live_count;

  assign fade_ext = (AGE_BITS + lla_pkg::AGE_W)'(fade_r);

  lla_rule #(
    .AGE_BITS (AGE_BITS)
  ) u_rule (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (rctl),
    .rd_cell      (now_rdata),
    .birth_mask   (birth_r),
    .survive_mask (surv_r),
    .fade         (fade_ext[AGE_BITS-1:0]),
    .nxt_cell     (nxt_cell),
    .live_count   (live_count)
  );

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lla_pkg::ST_IDLE;
      slot_r    <= lla_pkg::SLOT_CENTER;
      acc_ctr_r <= 1'b0;
      acc_nbr_r <= 1'b0;
      cp_v_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_ctr_r <= step_read && slot_r == lla_pkg::SLOT_CENTER;
      acc_nbr_r <= step_read && slot_r != lla_pkg::SLOT_CENTER && ag_valid;
      cp_v_r    <= state_r == lla_pkg::ST_COPY;
      if (xy_clr || slot_r == lla_pkg::SLOT_WRITE) begin
        slot_r <= lla_pkg::SLOT_CENTER;
      end else if (step_read) begin
        slot_r <= slot_r + lla_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xy_clr) begin
      x_r <= '0;
      y_r <= '0;
    end else if (xy_adv) begin
      if (x_r == x_last) begin
        x_r <= '0;
        y_r <= (y_r == y_last) ? '0 : y_r + YW'(1);
      end else begin
        x_r <= x_r + XW'(1);
      end
    end
    cp_addr_r <= ag_addr;
    in_area_r <= in_area;
  end

  // result register
  logic                       out_strobe_r;
  lla_pkg::res_t              out_res_r, out_res_nxt;
  logic [AGE_BITS+lla_pkg::AGE_W-1:0] rd_age_ext;

  assign rd_age_ext = (AGE_BITS + lla_pkg::AGE_W)'(now_rdata[AGE_BITS-1:0]);

  always_comb begin
    out_res_nxt = '0;
    if (state_r == lla_pkg::ST_READ && in_area_r) begin
      out_res_nxt.read_alive = now_rdata[AGE_BITS];
      out_res_nxt.read_age   = rd_age_ext[lla_pkg::AGE_W-1:0];
    end else if (state_r == lla_pkg::ST_FLUSH) begin
      out_res_nxt.live_count = live_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == lla_pkg::ST_IDLE && accept &&
                       in_req.req_type != lla_pkg::REQ_READ &&
                       in_req.req_type != lla_pkg::REQ_STEP) ||
                      state_r == lla_pkg::ST_READ ||
                      state_r == lla_pkg::ST_FLUSH;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for life_like_automaton_step: a scoreboard grid model
// predicts every load, read and generation step. Rule and size settings are
// changed between phases and include the extremes. Every cell is loaded
// before it is read or stepped over. Results are checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          GRID_COLS    = lla_pkg::MAX_WIDTH_DEF;
  localparam int          GRID_ROWS    = lla_pkg::MAX_HEIGHT_DEF;
  localparam int          GRID_CELLS   = GRID_COLS * GRID_ROWS;
  localparam int          LIMIT_CYCLES = 100_000;
  localparam int          GAP_MAX      = 18;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [lla_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = lla_pkg::CFG_FADE_START + 3'd1;
  localparam logic [lla_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = lla_pkg::CFG_FADE_START + 3'd2;

  typedef struct packed {
    logic                      alive;
    logic [lla_pkg::AGE_W-1:0] age;
  } cell_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          start     = 1'b0;
  logic                          busy;
  lla_pkg::req_t                 in_req    = '0;
  logic                          out_strobe;
  lla_pkg::res_t                 out_res;
  logic                          cfg_we    = 1'b0;
  logic [lla_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [lla_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // scoreboard copy of the block's settings, reset values
  logic [lla_pkg::SIZE_W-1:0] rule_cols    = 7'd64;
  logic [lla_pkg::SIZE_W-1:0] rule_rows    = 7'd64;
  logic                       rule_wrap    = 1'b0;
  logic [lla_pkg::MASK_W-1:0] rule_birth   = 9'd8;
  logic [lla_pkg::MASK_W-1:0] rule_survive = 9'd12;
  logic [lla_pkg::AGE_W-1:0]  rule_fade    = 4'd15;

  cell_t cell_mem [GRID_CELLS];
  cell_t next_mem [GRID_CELLS];

  lla_pkg::res_t awaited_res [$];
  lla_pkg::res_t checked_want;
  int            errors      = 0;
  int unsigned   cycle_count = 0;
  bit            no_idle     = 1'b0;

  life_like_automaton_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int active_cols();
    if (rule_cols == '0) return 1;
    if (rule_cols > GRID_COLS) return GRID_COLS;
    return int'(rule_cols);
  endfunction

  function automatic int active_rows();
    if (rule_rows == '0) return 1;
    if (rule_rows > GRID_ROWS) return GRID_ROWS;
    return int'(rule_rows);
  endfunction

  function automatic int live_neighbors(int x, int y, int w, int h);
    int n;
    int nx;
    int ny;
    n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (dx == 0 && dy == 0) continue;
        nx = x + dx;
        ny = y + dy;
        // on a narrow torus the same cell may be counted more than once
        if (nx < 0 || nx >= w) begin
          if (!rule_wrap) continue;
          nx = (nx < 0) ? w - 1 : 0;
        end
        if (ny < 0 || ny >= h) begin
          if (!rule_wrap) continue;
          ny = (ny < 0) ? h - 1 : 0;
        end
        if (cell_mem[ny * GRID_COLS + nx].alive) n++;
      end
    end
    return n;
  endfunction

  function automatic logic [lla_pkg::LIVE_W-1:0] advance_generation();
    int                         w;
    int                         h;
    int                         nbrs;
    int                         idx;
    cell_t                      cur;
    cell_t                      nxt;
    logic [lla_pkg::LIVE_W-1:0] live;
    w    = active_cols();
    h    = active_rows();
    live = '0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        idx  = y * GRID_COLS + x;
        cur  = cell_mem[idx];
        nxt  = cur;
        nbrs = live_neighbors(x, y, w, h);
        if (cur.alive) live = live + 1'b1;
        if (cur.age != '0) nxt.age = cur.age - 1'b1;
        if (cur.alive && !rule_survive[nbrs]) nxt = '{alive: 1'b0, age: rule_fade};
        if (!cur.alive && rule_birth[nbrs]) nxt = '{alive: 1'b1, age: rule_fade};
        next_mem[idx] = nxt;
      end
    end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        cell_mem[y * GRID_COLS + x] = next_mem[y * GRID_COLS + x];
    return live;
  endfunction

  function automatic lla_pkg::res_t predict_result(lla_pkg::req_t r);
    lla_pkg::res_t res;
    logic          in_area;
    int            idx;
    res     = '0;
    in_area = (int'(r.cell_x) < active_cols()) && (int'(r.cell_y) < active_rows());
    idx     = int'(r.cell_y) * GRID_COLS + int'(r.cell_x);
    case (r.req_type)
      lla_pkg::REQ_LOAD: begin
        if (in_area) cell_mem[idx] = '{alive: r.load_alive, age: r.load_age};
      end
      lla_pkg::REQ_STEP: begin
        res.live_count = advance_generation();
      end
      lla_pkg::REQ_READ: begin
        if (in_area) begin
          res.read_alive = cell_mem[idx].alive;
          res.read_age   = cell_mem[idx].age;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // -------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      if (awaited_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_res);
        errors++;
      end else begin
        checked_want = awaited_res.pop_front();
        if (out_res.read_alive !== checked_want.read_alive) begin
          $display("%0t: read_alive mismatch, expected %0d, actual %0d", $time,
                   checked_want.read_alive, out_res.read_alive);
          errors++;
        end
        if (out_res.read_age !== checked_want.read_age) begin
          $display("%0t: read_age mismatch, expected %0d, actual %0d", $time,
                   checked_want.read_age, out_res.read_age);
          errors++;
        end
        if (out_res.live_count !== checked_want.live_count) begin
          $display("%0t: live_count mismatch, expected %0d, actual %0d", $time,
                   checked_want.live_count, out_res.live_count);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------- drivers

  function automatic lla_pkg::req_t mk_req(logic [1:0] kind, int x, int y, logic alive,
                                           int age);
    lla_pkg::req_t r;
    r.req_type   = kind;
    r.cell_x     = 6'(x);
    r.cell_y     = 6'(y);
    r.load_alive = alive;
    r.load_age   = lla_pkg::AGE_W'(age);
    return r;
  endfunction

  // start stays high when the next item follows with no gap
  task automatic send_req(lla_pkg::req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_res.push_back(predict_result(r));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_res.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [lla_pkg::CFG_IDX_W-1:0] idx,
                           logic [lla_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      lla_pkg::CFG_GRID_WIDTH:   rule_cols    = data[lla_pkg::SIZE_W-1:0];
      lla_pkg::CFG_GRID_HEIGHT:  rule_rows    = data[lla_pkg::SIZE_W-1:0];
      lla_pkg::CFG_WRAP_EDGES:   rule_wrap    = data[0];
      lla_pkg::CFG_BIRTH_MASK:   rule_birth   = data[lla_pkg::MASK_W-1:0];
      lla_pkg::CFG_SURVIVE_MASK: rule_survive = data[lla_pkg::MASK_W-1:0];
      lla_pkg::CFG_FADE_START:   rule_fade    = data[lla_pkg::AGE_W-1:0];
      default: ;
    endcase
  endtask

  // unused bits of the write data are random; spare indexes must be ignored
  task automatic set_rule(int w, int h, logic wrap, logic [lla_pkg::MASK_W-1:0] birth,
                          logic [lla_pkg::MASK_W-1:0] survive,
                          logic [lla_pkg::AGE_W-1:0] fade);
    wait_idle();
    cfg_write(CFG_SPARE_A, lla_pkg::CFG_W'($urandom));
    cfg_write(CFG_SPARE_B, lla_pkg::CFG_W'($urandom));
    cfg_write(lla_pkg::CFG_GRID_WIDTH, {2'($urandom), 7'(w)});
    cfg_write(lla_pkg::CFG_GRID_HEIGHT, {2'($urandom), 7'(h)});
    cfg_write(lla_pkg::CFG_WRAP_EDGES, {8'($urandom), wrap});
    cfg_write(lla_pkg::CFG_BIRTH_MASK, birth);
    cfg_write(lla_pkg::CFG_SURVIVE_MASK, survive);
    cfg_write(lla_pkg::CFG_FADE_START, {5'($urandom), fade});
    cfg_we <= 1'b0;
  endtask

  task automatic fill_area(int alive_pct);
    for (int y = 0; y < active_rows(); y++)
      for (int x = 0; x < active_cols(); x++)
        send_req(mk_req(lla_pkg::REQ_LOAD, x, y, $urandom_range(0, 99) < alive_pct,
                        $urandom_range(0, 15)));
  endtask

  // ---------------------------------------------------------------- tests

  // only the size is written: birth, survive, fade and wrap keep reset values
  task automatic test_reset_rule();
    wait_idle();
    cfg_write(lla_pkg::CFG_GRID_WIDTH, 9'd5);
    cfg_write(lla_pkg::CFG_GRID_HEIGHT, 9'd5);
    cfg_we <= 1'b0;
    fill_area(0);
    // vertical blinker
    send_req(mk_req(lla_pkg::REQ_LOAD, 2, 1, 1'b1, 15));
    send_req(mk_req(lla_pkg::REQ_LOAD, 2, 2, 1'b1, 0));
    send_req(mk_req(lla_pkg::REQ_LOAD, 2, 3, 1'b1, 7));
    send_req(mk_req(lla_pkg::REQ_STEP, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 1, 2, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 2, 1, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 3, 2, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_STEP, 63, 63, 1'b1, 15));
    send_req(mk_req(lla_pkg::REQ_READ, 2, 1, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 1, 2, 1'b0, 0));
    // outside the active area: load ignored, read all zeros
    send_req(mk_req(lla_pkg::REQ_LOAD, 63, 63, 1'b1, 15));
    send_req(mk_req(lla_pkg::REQ_READ, 63, 63, 1'b1, 15));
    send_req(mk_req(lla_pkg::REQ_LOAD, 5, 0, 1'b1, 15));
    send_req(mk_req(lla_pkg::REQ_READ, 5, 0, 1'b0, 0));
    send_req(mk_req(REQ_UNUSED, 2, 2, 1'b1, 15));
    send_req(mk_req(lla_pkg::REQ_READ, 2, 2, 1'b0, 0));
  endtask

  task automatic test_size_extremes();
    // size zero acts as one; on a 1x1 torus the cell is its own 8 neighbors
    set_rule(0, 0, 1'b1, 9'h100, 9'h100, 4'd0);
    fill_area(100);
    send_req(mk_req(lla_pkg::REQ_STEP, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_LOAD, 1, 0, 1'b1, 9));
    send_req(mk_req(lla_pkg::REQ_READ, 1, 0, 1'b0, 0));
    set_rule(0, 0, 1'b1, 9'h000, 9'h000, 4'd15);
    send_req(mk_req(lla_pkg::REQ_STEP, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_STEP, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 0, 0, 1'b0, 0));
    set_rule(2, 2, 1'b1, 9'h1FF, 9'h000, 4'd7);
    fill_area(50);
    send_req(mk_req(lla_pkg::REQ_STEP, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 1, 1, 1'b0, 0));
    // width above the maximum acts as the maximum
    set_rule(127, 1, 1'b1, 9'h1FF, 9'h1FF, 4'd15);
    fill_area(50);
    send_req(mk_req(lla_pkg::REQ_READ, 63, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_STEP, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 63, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 62, 0, 1'b0, 0));
    // height above the maximum: the last row is in the area
    set_rule(1, 100, 1'b1, 9'h0F0, 9'h00F, 4'd9);
    send_req(mk_req(lla_pkg::REQ_LOAD, 0, 63, 1'b1, 5));
    send_req(mk_req(lla_pkg::REQ_READ, 0, 63, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 0, 0, 1'b0, 0));
    send_req(mk_req(lla_pkg::REQ_READ, 1, 63, 1'b0, 0));
  endtask

  task automatic test_random_rules();
    int   w;
    int   h;
    int   pick;
    int   x;
    int   y;
    for (int phase = 0; phase < 2; phase++) begin
      w = $urandom_range(0, 4);
      h = $urandom_range(0, 4);
      set_rule(w, h, 1'($urandom), lla_pkg::MASK_W'($urandom), lla_pkg::MASK_W'($urandom),
               lla_pkg::AGE_W'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      fill_area($urandom_range(20, 60));
      for (int k = 0; k < 8; k++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) != 0) begin
          x = $urandom_range(0, active_cols() - 1);
          y = $urandom_range(0, active_rows() - 1);
        end else begin
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
        end
        if (pick < 45)
          send_req(mk_req(lla_pkg::REQ_LOAD, x, y, 1'($urandom), $urandom_range(0, 15)));
        else if (pick < 80)
          send_req(mk_req(lla_pkg::REQ_READ, x, y, 1'($urandom), $urandom_range(0, 15)));
        else if (pick < 93)
          send_req(mk_req(lla_pkg::REQ_STEP, x, y, 1'($urandom), $urandom_range(0, 15)));
        else
          send_req(mk_req(REQ_UNUSED, x, y, 1'($urandom), $urandom_range(0, 15)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < GRID_CELLS; i++) begin
      cell_mem[i] = '0;
      next_mem[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_rule();
    test_size_extremes();
    test_random_rules();
    wait_idle();
    repeat (30) @(posedge clk);
    if (errors == 0 && awaited_res.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
